// ===== hdl/plu_pkg.sv =====
// Package for the particle lifetime update pipeline.
// Holds the transaction structs, fixed-point widths and lane saturation.
// No dependencies.
package plu_pkg;

    localparam int LW  = 21;
    localparam int NL  = 3;
    localparam int PW  = LW + 17;
    localparam int SW  = LW + 4;
    localparam int TW  = 24;
    localparam int DW  = 40;
    localparam int AW  = 32;
    localparam int QW  = 16;
    localparam int AQW = 8;
    localparam int FSH = 16;

    localparam int FLAG_VEL    = 0;
    localparam int FLAG_GRAV   = 1;
    localparam int FLAG_SIZE   = 2;
    localparam int FLAG_ANCHOR = 3;

    typedef struct packed {
        logic [15:0]     delta_time;
        logic [TW-1:0]   time_left;
        logic [TW-1:0]   total_time;
        logic [3:0]      flags;
        logic [62:0]     position;
        logic [62:0]     velocity;
        logic [62:0]     gravity;
        logic [62:0]     anchor_now;
        logic [62:0]     anchor_prev;
        logic [15:0]     scale_from;
        logic [15:0]     scale_to;
        logic [7:0]      base_alpha;
    } t_in;

    typedef struct packed {
        logic            alive;
        logic [TW-1:0]   new_time_left;
        logic [62:0]     new_position;
        logic [62:0]     new_velocity;
        logic [62:0]     new_anchor_prev;
        logic [15:0]     new_scale;
        logic [7:0]      new_alpha;
    } t_out;

    typedef struct packed {
        logic            alive;
        logic [TW-1:0]   time_left;
        logic [62:0]     position;
        logic [62:0]     velocity;
        logic [62:0]     anchor_prev;
        logic [15:0]     scale_from;
        logic [DW-1:0]   rem_s;
        logic [TW-1:0]   divisor;
        logic [QW-1:0]   q_s;
        logic [AW-1:0]   rem_a;
        logic [AQW-1:0]  q_a;
        logic            skip_a;
    } t_div;

    function automatic logic [LW-1:0] sat_lane(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'($signed({1'b0, {(LW-1){1'b1}}}));
        lo = -hi - SW'(1);
        if (x > hi) begin
            return hi[LW-1:0];
        end else if (x < lo) begin
            return lo[LW-1:0];
        end
        return x[LW-1:0];
    endfunction

endpackage

// ===== hdl/plu_front.sv =====
// Front end of the particle lifetime update: life, lane products and lane sums.
// Three register stages; uses plu_pkg.
module plu_front
    import plu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_in   i_item,
    output logic  o_vld,
    output t_div  o_div
);

    logic                 r1_vld, r2_vld, r3_vld;
    t_in                  r1_item, r2_item;
    logic [TW-1:0]        r1_remain, r2_remain;
    logic                 r1_dead, r2_dead;
    logic [TW-1:0]        r1_elapsed;
    logic [15:0]          r1_diff;
    logic signed [PW-1:0] r2_pv [NL];
    logic signed [PW-1:0] r2_pg [NL];
    logic [DW-1:0]        r2_num_s;
    logic [AW-1:0]        r2_num_a;
    t_div                 r3_div;

    logic [TW-1:0]        n1_remain;
    logic [TW-1:0]        n1_elapsed;
    logic [15:0]          n1_diff;
    t_div                 n3_div;

    always_comb begin
        logic do_size;
        n1_remain = i_item.time_left - TW'(i_item.delta_time);
        do_size = i_item.flags[FLAG_SIZE] && (i_item.total_time != '0);
        if (do_size && i_item.total_time > n1_remain) begin
            n1_elapsed = i_item.total_time - n1_remain;
        end else begin
            n1_elapsed = '0;
        end
        if (!do_size) begin
            n1_diff = '0;
        end else if (i_item.scale_to >= i_item.scale_from) begin
            n1_diff = i_item.scale_to - i_item.scale_from;
        end else begin
            n1_diff = i_item.scale_from - i_item.scale_to;
        end
    end

    always_comb begin
        logic signed [SW-1:0] p, v, vs, gs, ad, pn, vn;
        logic [62:0]          npos, nvel;
        logic                 tz;
        npos = '0;
        nvel = '0;
        for (int k = 0; k < NL; k++) begin
            p  = SW'($signed(r2_item.position[k*LW +: LW]));
            v  = SW'($signed(r2_item.velocity[k*LW +: LW]));
            vs = SW'($signed(r2_pv[k][PW-1:FSH]));
            gs = SW'($signed(r2_pg[k][PW-1:FSH]));
            ad = SW'($signed(r2_item.anchor_now[k*LW +: LW]))
                 - SW'($signed(r2_item.anchor_prev[k*LW +: LW]));
            pn = p;
            vn = v;
            if (r2_item.flags[FLAG_VEL]) begin
                pn = pn + vs;
            end
            if (r2_item.flags[FLAG_GRAV]) begin
                pn = pn + gs;
                vn = vn + gs;
            end
            if (r2_item.flags[FLAG_ANCHOR]) begin
                pn = pn + ad;
            end
            npos[k*LW +: LW] = sat_lane(pn);
            nvel[k*LW +: LW] = sat_lane(vn);
        end
        tz = (r2_item.total_time == '0);
        n3_div.alive       = !r2_dead;
        n3_div.time_left   = r2_remain;
        n3_div.position    = npos;
        n3_div.velocity    = nvel;
        n3_div.anchor_prev = r2_item.flags[FLAG_ANCHOR] ? r2_item.anchor_now
                                                        : r2_item.anchor_prev;
        n3_div.scale_from  = r2_item.scale_from;
        n3_div.rem_s       = r2_num_s;
        n3_div.divisor     = tz ? TW'(1) : r2_item.total_time;
        n3_div.q_s         = '0;
        n3_div.rem_a       = r2_num_a;
        if (tz) begin
            n3_div.q_a    = r2_item.base_alpha;
            n3_div.skip_a = 1'b1;
        end else if (r2_num_a >= {r2_item.total_time, 8'b0}) begin
            n3_div.q_a    = '1;
            n3_div.skip_a = 1'b1;
        end else begin
            n3_div.q_a    = '0;
            n3_div.skip_a = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item    <= i_item;
            r1_remain  <= n1_remain;
            r1_dead    <= (i_item.time_left <= TW'(i_item.delta_time));
            r1_elapsed <= n1_elapsed;
            r1_diff    <= n1_diff;

            r2_item    <= r1_item;
            r2_remain  <= r1_remain;
            r2_dead    <= r1_dead;
            for (int k = 0; k < NL; k++) begin
                r2_pv[k] <= $signed(r1_item.velocity[k*LW +: LW])
                            * $signed({1'b0, r1_item.delta_time});
                r2_pg[k] <= $signed(r1_item.gravity[k*LW +: LW])
                            * $signed({1'b0, r1_item.delta_time});
            end
            r2_num_s   <= DW'(r1_diff) * DW'(r1_elapsed);
            r2_num_a   <= AW'(r1_item.base_alpha) * AW'(r1_remain);

            r3_div     <= n3_div;
        end
    end

    assign o_vld = r3_vld;
    assign o_div = r3_div;

endmodule

// ===== hdl/plu_div_stage.sv =====
// One restoring division stage: resolves one scale quotient bit and,
// for the low bits, one alpha quotient bit. Uses plu_pkg.
module plu_div_stage
    import plu_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_div  i_div,
    output logic  o_vld,
    output t_div  o_div
);

    logic r_vld;
    t_div r_div;
    t_div n_div;

    always_comb begin
        logic [DW-1:0] ds;
        logic [AW-1:0] da;
        n_div = i_div;
        ds = DW'(i_div.divisor) << BIT;
        if (i_div.rem_s >= ds) begin
            n_div.rem_s    = i_div.rem_s - ds;
            n_div.q_s[BIT] = 1'b1;
        end
        if (BIT < AQW) begin
            da = AW'(i_div.divisor) << BIT;
            if (!i_div.skip_a && i_div.rem_a >= da) begin
                n_div.rem_a = i_div.rem_a - da;
                n_div.q_a[BIT % AQW] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

// ===== hdl/particle_lifetime_update.sv =====
// Particle lifetime update: Euler step of one particle record per transaction.
// The pipeline has three front stages, sixteen divider stages and one output stage.
// Throughput is one transaction per cycle while the output is not stalled; the 16 one-bit divider stages set the depth.
// The whole pipeline holds while a finished result is stalled at the output.
// Synchronous active-low reset clears all valid bits.
module particle_lifetime_update
    import plu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_item
);

    logic en;
    logic vld [QW+1];
    t_div dv  [QW+1];
    logic r_out_vld;
    t_out r_out;
    t_out n_out;

    assign en = !(r_out_vld && i_stall);

    plu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_item  (i_item),
        .o_vld   (vld[0]),
        .o_div   (dv[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_div
        plu_div_stage #(
            .BIT (QW - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[g]),
            .i_div   (dv[g]),
            .o_vld   (vld[g+1]),
            .o_div   (dv[g+1])
        );
    end

    always_comb begin
        logic [16:0] s;
        s = 17'(dv[QW].scale_from) + 17'(dv[QW].q_s);
        n_out = '0;
        if (dv[QW].alive) begin
            n_out.alive           = 1'b1;
            n_out.new_time_left   = dv[QW].time_left;
            n_out.new_position    = dv[QW].position;
            n_out.new_velocity    = dv[QW].velocity;
            n_out.new_anchor_prev = dv[QW].anchor_prev;
            n_out.new_scale       = s[16] ? 16'hFFFF : s[15:0];
            n_out.new_alpha       = dv[QW].q_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// ===== test/testbench.sv =====
// Testbench for the particle lifetime update pipeline.
// Predicts each result from the input transaction and checks it in order against the block.
// Depends on plu_pkg and particle_lifetime_update.
module testbench;
    import plu_pkg::*;

    class lifetime_board;
        t_out pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic signed [LW-1:0] lane(input logic [62:0] v, input int k);
            return v[k*LW +: LW];
        endfunction

        function automatic longint step_scaled(input longint x, input longint dt);
            longint p;
            p = x * dt;
            if (p >= 0) begin
                return p / 65536;
            end
            return -((-p + 65535) / 65536);
        endfunction

        function automatic logic [LW-1:0] clamp_lane(input longint x);
            longint hi;
            longint lo;
            hi = (longint'(1) << (LW - 1)) - 1;
            lo = -hi - 1;
            if (x > hi) begin
                x = hi;
            end
            if (x < lo) begin
                x = lo;
            end
            return x[LW-1:0];
        endfunction

        function automatic void note_input(input t_in t);
            t_out r;
            longint dt, remain, tt, v, g, p, gs, d, el, df, sc, a;
            r = '0;
            dt = t.delta_time;
            tt = t.total_time;
            if (t.time_left > t.delta_time) begin
                remain = longint'(t.time_left) - dt;
                for (int k = 0; k < NL; k++) begin
                    v = lane(t.velocity, k);
                    g = lane(t.gravity, k);
                    p = lane(t.position, k);
                    gs = step_scaled(g, dt);
                    d = 0;
                    if (t.flags[FLAG_VEL]) begin
                        d += step_scaled(v, dt);
                    end
                    if (t.flags[FLAG_GRAV]) begin
                        d += gs;
                        v += gs;
                    end
                    if (t.flags[FLAG_ANCHOR]) begin
                        d += longint'(lane(t.anchor_now, k)) - lane(t.anchor_prev, k);
                    end
                    r.new_position[k*LW +: LW] = clamp_lane(p + d);
                    r.new_velocity[k*LW +: LW] = clamp_lane(v);
                end
                if (t.flags[FLAG_SIZE] && tt != 0) begin
                    el = (tt > remain) ? tt - remain : 0;
                    df = (t.scale_to >= t.scale_from) ? t.scale_to - t.scale_from
                                                      : t.scale_from - t.scale_to;
                    sc = t.scale_from + (df * el) / tt;
                    if (sc > 65535) begin
                        sc = 65535;
                    end
                end else begin
                    sc = t.scale_from;
                end
                if (tt == 0) begin
                    a = t.base_alpha;
                end else begin
                    a = (longint'(t.base_alpha) * remain) / tt;
                    if (a > 255) begin
                        a = 255;
                    end
                end
                r.alive = 1'b1;
                r.new_time_left = remain[TW-1:0];
                r.new_anchor_prev = t.flags[FLAG_ANCHOR] ? t.anchor_now : t.anchor_prev;
                r.new_scale = sc[15:0];
                r.new_alpha = a[7:0];
            end
            pending.push_back(r);
        endfunction

        function automatic void check_result(input t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.alive !== e.alive) begin
                $display("%0t: alive exp %h got %h", $time, e.alive, got.alive);
                errors++;
            end
            if (got.new_time_left !== e.new_time_left) begin
                $display("%0t: time_left exp %h got %h", $time, e.new_time_left,
                         got.new_time_left);
                errors++;
            end
            if (got.new_position !== e.new_position) begin
                $display("%0t: position exp %h got %h", $time, e.new_position,
                         got.new_position);
                errors++;
            end
            if (got.new_velocity !== e.new_velocity) begin
                $display("%0t: velocity exp %h got %h", $time, e.new_velocity,
                         got.new_velocity);
                errors++;
            end
            if (got.new_anchor_prev !== e.new_anchor_prev) begin
                $display("%0t: anchor_prev exp %h got %h", $time, e.new_anchor_prev,
                         got.new_anchor_prev);
                errors++;
            end
            if (got.new_scale !== e.new_scale) begin
                $display("%0t: scale exp %h got %h", $time, e.new_scale, got.new_scale);
                errors++;
            end
            if (got.new_alpha !== e.new_alpha) begin
                $display("%0t: alpha exp %h got %h", $time, e.new_alpha, got.new_alpha);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_item = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_item;

    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;
    lifetime_board board = new();

    particle_lifetime_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_item);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    function automatic logic [62:0] rand_lanes(input int mode);
        logic [62:0] v;
        v = 63'({$urandom, $urandom});
        for (int k = 0; k < NL; k++) begin
            case (mode)
                0: v[k*LW +: LW] = LW'($signed(8'($urandom)));
                1: v[k*LW +: LW] = {1'b0, {(LW-1){1'b1}}};
                2: v[k*LW +: LW] = {1'b1, {(LW-1){1'b0}}};
                default: ;
            endcase
        end
        return v;
    endfunction

    function automatic t_in rand_item(input int mode);
        t_in t;
        t.delta_time = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
        t.total_time = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(1, 900000));
        case ($urandom_range(5))
            0: t.time_left = 24'($urandom);
            1: t.time_left = 24'($urandom_range(t.delta_time));
            2: t.time_left = t.total_time + 24'($urandom_range(2000));
            default: t.time_left = 24'($urandom_range(t.total_time) + t.delta_time + 1);
        endcase
        t.flags = 4'($urandom);
        t.position = rand_lanes(mode);
        t.velocity = rand_lanes($urandom_range(3));
        t.gravity = rand_lanes($urandom_range(3));
        t.anchor_now = rand_lanes($urandom_range(3));
        t.anchor_prev = rand_lanes($urandom_range(3));
        t.scale_from = 16'($urandom);
        t.scale_to = 16'($urandom);
        t.base_alpha = 8'($urandom);
        return t;
    endfunction

    task automatic send(input t_in t);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= t;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        board.note_input(t);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_in t;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, dead particles, every flag, saturation.
        for (int n = 0; n < 24; n++) begin
            t = rand_item(n % 4);
            t.flags = 4'(n);
            case (n)
                0: begin t = '0; t.total_time = 24'd1; end
                1: begin t = '1; end
                2: begin t.time_left = TW'(t.delta_time); end
                3: begin t.delta_time = 16'hFFFF; t.time_left = 24'hFFFFFF;
                         t.total_time = 24'd1; t.base_alpha = 8'hFF; end
                4: begin t.delta_time = '0; t.time_left = 24'd1; end
                5: begin t.scale_from = 16'hFFFF; t.scale_to = '0;
                         t.time_left = 24'(t.delta_time + 1); t.total_time = 24'hFFFFFF; end
                6: begin t.scale_from = 16'hFFFF; t.scale_to = 16'hFFFF; end
                7: begin t.total_time = 24'hFFFFFF; t.time_left = 24'hFFFFFF; end
                default: ;
            endcase
            if (n >= 8) begin
                t.flags = (n % 2 == 1) ? 4'hF : 4'($urandom_range(15));
                t.delta_time = 16'hFFFF;
                t.time_left = 24'hFFFFFF;
            end
            send(t);
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 83; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 83; end
                3: begin send_idle = 14; recv_stall = 14; end
                default: begin send_idle = 0; recv_stall = 0; hold_off = 200; end
            endcase
            for (int n = 0; n < 150; n++) begin
                send(rand_item($urandom_range(3)));
            end
            drain();
        end
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/plu_pkg.sv
hdl/plu_front.sv
hdl/plu_div_stage.sv
hdl/particle_lifetime_update.sv
test/testbench.sv
